FILE: sv/assert_macros.svh
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, disabled while rst is high
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that the given condition holds whenever result_valid is high
`define CHK_RESULT(label, cond, msg) \
  `CHK_ASSERT(label, result_valid |-> (cond), msg)

`endif

FILE: sv/skl_pkg.sv
// ----------------------------------------------------------------------------
// skl_pkg
// Types and constants for the string key linear probe table.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int TABLE_SIZE  = 1024;
  localparam int MAX_KEY_LEN = 32;
  localparam int SLOT_W      = $clog2(TABLE_SIZE);
  localparam int KIDX_W      = $clog2(MAX_KEY_LEN);
  localparam int LEN_W       = $clog2(MAX_KEY_LEN + 1);
  localparam int BADDR_W     = SLOT_W + KIDX_W;
  localparam int HASH_W      = 28;
  localparam int MOD_W       = 11;
  localparam int PROBE_W     = 11;

  localparam logic [MOD_W-1:0]   MOD_RESET  = MOD_W'(1021);
  localparam logic [PROBE_W-1:0] PROBES_MAX = PROBE_W'(TABLE_SIZE);

  localparam logic CMD_FIND   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] key_byte;
    logic       key_last;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [9:0]         slot;
    logic [PROBE_W-1:0] probes;
    logic [1:0]         status;
  } result_t;

endpackage

FILE: sv/skl_ram.sv
// ----------------------------------------------------------------------------
// skl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skl_ram #(
  parameter int AW = 10,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/skl_div.sv
// ----------------------------------------------------------------------------
// skl_div
// Bit-serial restoring remainder unit: hash modulo the table modulus.
// ----------------------------------------------------------------------------
module skl_div import skl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [MOD_W-1:0]  divisor,
  output logic              done,
  output logic [MOD_W-1:0]  rem
);

  localparam int CNT_W = $clog2(HASH_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [HASH_W-1:0] num;
  logic [MOD_W-1:0]  den;
  logic [MOD_W:0]    trial;

  assign trial = {rem, num[HASH_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        num <= {num[HASH_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem <= MOD_W'(trial - {1'b0, den});
        end else begin
          rem <= trial[MOD_W-1:0];
        end
        if (cnt == CNT_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/string_key_linear_probe_table_unit.sv
// ----------------------------------------------------------------------------
// string_key_linear_probe_table_unit
// Open-addressing string key table, ELF hash, linear probing.
// ----------------------------------------------------------------------------
// Key bytes are taken one per cycle while the unit is idle. The beat with
// key_last starts the lookup: the serial remainder unit gives the home slot,
// each probe then reads the slot length and compares the stored bytes one by
// one, and an insert copies the key bytes into the slot, all through the
// single read port of each memory. A result waits in an output register and
// the next key is taken once it has gone. After reset a clearing pass over
// all 1024 slots empties the length memory before the first byte is taken.
module string_key_linear_probe_table_unit import skl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_ready,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MOD_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_LEN_RD, S_LEN_CHK, S_CMP_RD, S_CMP_CHK, S_CP_RD, S_CP_WR
  } state_t;

  state_t             state;
  logic [MOD_W-1:0]   hash_modulus;
  logic [HASH_W-1:0]  hash;
  logic [LEN_W-1:0]   count;
  logic               too_long;
  logic               cmd;
  logic [SLOT_W-1:0]  home;
  logic [SLOT_W-1:0]  s;
  logic [PROBE_W-1:0] n;
  logic [KIDX_W-1:0]  idx;
  logic [SLOT_W-1:0]  clr_addr;

  logic               accept;
  logic [31:0]        h_shift;
  logic [HASH_W-1:0]  hash_next;
  logic               too_long_next;
  logic [LEN_W-1:0]   count_next;
  logic [LEN_W-1:0]   cnt_m1;
  logic [PROBE_W-1:0] n_inc;
  logic               div_start;
  logic               div_done;
  logic [MOD_W-1:0]   div_rem;

  logic               len_we;
  logic [SLOT_W-1:0]  len_waddr;
  logic [LEN_W-1:0]   len_wdata;
  logic [LEN_W-1:0]   len_rdata;
  logic               kb_we;
  logic [7:0]         kb_rdata;
  logic               sb_we;
  logic [7:0]         sb_rdata;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == S_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;

  // ELF hash update
  always_comb begin
    h_shift   = {hash, 4'b0} + {24'b0, item.key_byte};
    hash_next = h_shift[HASH_W-1:0] ^ {20'b0, h_shift[31:28], 4'b0};
  end

  assign too_long_next = too_long || (count == LEN_W'(MAX_KEY_LEN));
  assign count_next    = too_long_next ? count : count + 1'b1;
  assign cnt_m1        = count - 1'b1;
  assign n_inc         = n + 1'b1;
  assign div_start     = accept && item.key_last && !too_long_next;
  assign kb_we         = accept && !too_long_next;
  assign sb_we         = (state == S_CP_WR);

  always_comb begin
    len_we    = 1'b0;
    len_waddr = s;
    len_wdata = count;
    if (state == S_CLR) begin
      len_we    = 1'b1;
      len_waddr = clr_addr;
      len_wdata = '0;
    end else if (state == S_LEN_CHK && len_rdata == '0 && cmd == CMD_INSERT) begin
      len_we = 1'b1;
    end
  end

  skl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hash_next),
    .divisor  ((hash_modulus == '0) ? MOD_W'(1) : hash_modulus),
    .done     (div_done),
    .rem      (div_rem)
  );

  skl_ram #(.AW(SLOT_W), .DW(LEN_W)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (s),
    .rdata (len_rdata)
  );

  skl_ram #(.AW(KIDX_W), .DW(8)) u_key_ram (
    .clk   (clk),
    .we    (kb_we),
    .waddr (count[KIDX_W-1:0]),
    .wdata (item.key_byte),
    .raddr (idx),
    .rdata (kb_rdata)
  );

  skl_ram #(.AW(BADDR_W), .DW(8)) u_slot_ram (
    .clk   (clk),
    .we    (sb_we),
    .waddr ({s, idx}),
    .wdata (kb_rdata),
    .raddr ({s, idx}),
    .rdata (sb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      hash_modulus <= MOD_RESET;
      hash         <= '0;
      count        <= '0;
      too_long     <= 1'b0;
      result_valid <= 1'b0;
      s            <= '0;
      idx          <= '0;
    end else begin
      if (cfg_valid) begin
        hash_modulus <= cfg_data;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_W'(TABLE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          // a pending result only ever waits here
          if (accept && item.key_last && too_long_next) begin
            result_valid <= 1'b1;
            result       <= '{found: 1'b0, slot: '0, probes: '0, status: ST_LONG};
          end else if (result_valid && result_ready) begin
            result_valid <= 1'b0;
          end
          if (accept) begin
            if (item.key_last) begin
              hash     <= '0;
              too_long <= 1'b0;
              cmd      <= item.command;
              if (too_long_next) begin
                count <= '0;
              end else begin
                count <= count_next;
                state <= S_DIV;
              end
            end else begin
              hash     <= hash_next;
              count    <= count_next;
              too_long <= too_long_next;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            home  <= div_rem[SLOT_W-1:0];
            s     <= div_rem[SLOT_W-1:0];
            n     <= '0;
            state <= S_LEN_RD;
          end
        end
        S_LEN_RD: begin
          state <= S_LEN_CHK;
        end
        S_LEN_CHK: begin
          n   <= n_inc;
          idx <= '0;
          if (len_rdata == '0) begin
            if (cmd == CMD_INSERT) begin
              state <= S_CP_RD;
            end else begin
              result_valid <= 1'b1;
              result       <= '{found: 1'b0, slot: s, probes: n_inc, status: ST_OK};
              count        <= '0;
              state        <= S_IDLE;
            end
          end else if (len_rdata == count) begin
            state <= S_CMP_RD;
          end else if (n_inc == PROBES_MAX) begin
            result_valid <= 1'b1;
            result       <= '{found: 1'b0, slot: home, probes: n_inc, status: ST_FULL};
            count        <= '0;
            state        <= S_IDLE;
          end else begin
            s     <= s + 1'b1;
            state <= S_LEN_RD;
          end
        end
        S_CMP_RD: begin
          state <= S_CMP_CHK;
        end
        S_CMP_CHK: begin
          if (sb_rdata != kb_rdata) begin
            if (n == PROBES_MAX) begin
              result_valid <= 1'b1;
              result       <= '{found: 1'b0, slot: home, probes: n, status: ST_FULL};
              count        <= '0;
              state        <= S_IDLE;
            end else begin
              s     <= s + 1'b1;
              state <= S_LEN_RD;
            end
          end else if ({1'b0, idx} == cnt_m1) begin
            result_valid <= 1'b1;
            result       <= '{found: 1'b1, slot: s, probes: n, status: ST_OK};
            count        <= '0;
            state        <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_CMP_RD;
          end
        end
        S_CP_RD: begin
          state <= S_CP_WR;
        end
        S_CP_WR: begin
          if ({1'b0, idx} == cnt_m1) begin
            result_valid <= 1'b1;
            result       <= '{found: 1'b0, slot: s, probes: n, status: ST_OK};
            count        <= '0;
            state        <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_CP_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/skl_checker.sv
// ----------------------------------------------------------------------------
// skl_checker
// Port-level checks on the result channel of the probe table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skl_checker import skl_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  `CHK_ASSERT(a_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result beat changed while stalled")
  `CHK_RESULT(a_ok_probes, result.status != ST_OK || result.probes != '0, "ok result with no probes")
  `CHK_RESULT(a_full, result.status != ST_FULL || (result.probes == PROBES_MAX && !result.found), "bad full result")
  `CHK_RESULT(a_long, result.status != ST_LONG || (result.probes == '0 && result.slot == '0 && !result.found), "bad too-long result")

endmodule

bind string_key_linear_probe_table_unit skl_checker u_skl_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
